>>> design/tun_pkg.sv
// Shared types and constants for the triangle unit normal pipeline.
// No dependencies; the files that use it refer to it by scoped names.
package tun_pkg;

	// Component magnitudes are cut down to this many bits before normalising.
	localparam int RED_BITS = 30;

	// Sideband that travels with each item through the divide/root lanes.
	typedef struct packed {
		logic vld;
		logic neg;
		logic degen;
	} tun_tag_t;

endpackage

>>> design/tun_if.sv
// Channel interfaces for the triangle unit normal block: triangle input,
// normal output and the winding register write. Depends on nothing.
interface tun_tri_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tun_norm_if #(parameter int NW = 32);
	logic valid;
	logic ready;
	logic signed [NW-1:0] normal_x, normal_y, normal_z;
	logic degenerate;
	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

interface tun_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> design/tun_lane.sv
// One normalisation lane: pipelined restoring divide of m*m*2^(2F+2) by S,
// one quotient bit per stage, then a digit-by-digit square root, one root
// bit per stage. Depends on tun_pkg.
module tun_lane #(
	parameter int NF = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  tun_pkg::tun_tag_t                 tag_in,
	input  logic [2*tun_pkg::RED_BITS-1:0]    sq,
	input  logic [2*tun_pkg::RED_BITS+1:0]    s,
	output tun_pkg::tun_tag_t                 tag_out,
	output logic [NF+1:0]                     root
);
	localparam int SW   = 2*tun_pkg::RED_BITS + 2;
	localparam int QW   = 2*NF + 3;
	localparam int TW   = NF + 2;
	localparam int RTW  = TW + 3;
	localparam int PADW = 2*TW;

	logic [SW-1:0]     drem [QW];
	logic [SW-1:0]     ds   [QW];
	logic [QW-1:0]     dq   [QW];
	tun_pkg::tun_tag_t dtag [QW];

	logic [RTW-1:0]    rrem  [TW];
	logic [TW-1:0]     rroot [TW];
	logic [PADW-1:0]   rq    [TW];
	tun_pkg::tun_tag_t rtag  [TW];

	genvar i;
	generate
		for (i = 0; i < QW; i++) begin : g_div
			logic [SW:0] sh;
			logic        ge;
			logic [SW:0] dif;
			if (i == 0) begin : g_first
				assign sh = {1'b0, 2'b00, sq};
				assign ge = sh >= {1'b0, s};
				assign dif = sh - {1'b0, s};
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						dtag[i] <= '0;
					end else if (adv) begin
						dtag[i] <= tag_in;
						ds[i]   <= s;
						drem[i] <= ge ? dif[SW-1:0] : sh[SW-1:0];
						dq[i]   <= QW'(ge);
					end
				end
			end else begin : g_next
				assign sh = {drem[i-1], 1'b0};
				assign ge = sh >= {1'b0, ds[i-1]};
				assign dif = sh - {1'b0, ds[i-1]};
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						dtag[i] <= '0;
					end else if (adv) begin
						dtag[i] <= dtag[i-1];
						ds[i]   <= ds[i-1];
						drem[i] <= ge ? dif[SW-1:0] : sh[SW-1:0];
						dq[i]   <= {dq[i-1][QW-2:0], ge};
					end
				end
			end
		end

		for (i = 0; i < TW; i++) begin : g_root
			logic [RTW-1:0]    rem_p;
			logic [TW-1:0]     root_p;
			logic [PADW-1:0]   q_p;
			tun_pkg::tun_tag_t tag_p;
			logic [RTW-1:0]    remsh;
			logic [RTW-1:0]    trial;
			logic              ge;
			if (i == 0) begin : g_first
				assign rem_p  = '0;
				assign root_p = '0;
				assign q_p    = PADW'(dq[QW-1]);
				assign tag_p  = dtag[QW-1];
			end else begin : g_next
				assign rem_p  = rrem[i-1];
				assign root_p = rroot[i-1];
				assign q_p    = rq[i-1];
				assign tag_p  = rtag[i-1];
			end
			assign remsh = {rem_p[RTW-3:0], q_p[PADW-1-2*i -: 2]};
			assign trial = RTW'({root_p, 2'b01});
			assign ge    = remsh >= trial;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rtag[i] <= '0;
				end else if (adv) begin
					rtag[i]  <= tag_p;
					rq[i]    <= q_p;
					rrem[i]  <= ge ? remsh - trial : remsh;
					rroot[i] <= {root_p[TW-2:0], ge};
				end
			end
		end
	endgenerate

	assign tag_out = rtag[TW-1];
	assign root    = rroot[TW-1];
endmodule

>>> design/triangle_unit_normal.sv
// Top level of the triangle unit normal pipeline: edges, cross product,
// magnitude reduction, sums of squares and three tun_lane instances.
// Depends on tun_pkg, tun_if and tun_lane.
//
//  channel   dir  handshake      payload
//  tri_in    in   valid/ready    a_x..c_z, signed COORD_WIDTH
//  norm_out  out  valid/ready    normal_x/y/z signed NF+2, degenerate
//  cfg       in   valid/ready    data = winding_clockwise
//
// One triangle per cycle while norm_out is not stalled; the divider and
// square-root lanes resolve one bit per stage.
// Reset clears all valid bits and the winding register to counter-clockwise.
// The whole pipe advances together whenever the output register is empty or
// taken; otherwise every stage holds, so a stall drops and repeats nothing.
module triangle_unit_normal #(
	parameter int COORD_WIDTH      = 32,
	parameter int NORMAL_FRAC_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	tun_tri_if.sink     tri_in,
	tun_norm_if.source  norm_out,
	tun_cfg_if.sink     cfg
);
	localparam int CW   = COORD_WIDTH;
	localparam int NF   = NORMAL_FRAC_BITS;
	localparam int RED  = tun_pkg::RED_BITS;
	localparam int DW   = CW + 1;
	localparam int PW   = 2*DW;
	localparam int XW   = PW + 1;
	localparam int LW   = $clog2(XW + 1);
	localparam int SW   = 2*RED + 2;
	localparam int TW   = NF + 2;

	logic winding_clockwise_q;
	logic adv;
	logic out_vld_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			winding_clockwise_q <= 1'b0;
		end else if (cfg.valid) begin
			winding_clockwise_q <= cfg.data;
		end
	end

	assign adv          = !out_vld_q || norm_out.ready;
	assign tri_in.ready = adv;

	// stage 1: edges
	logic                 vld_s1, cw_s1;
	logic signed [DW-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= tri_in.valid;
			cw_s1  <= winding_clockwise_q;
			ux_s1  <= $signed({tri_in.b_x[CW-1], tri_in.b_x}) - $signed({tri_in.a_x[CW-1], tri_in.a_x});
			uy_s1  <= $signed({tri_in.b_y[CW-1], tri_in.b_y}) - $signed({tri_in.a_y[CW-1], tri_in.a_y});
			uz_s1  <= $signed({tri_in.b_z[CW-1], tri_in.b_z}) - $signed({tri_in.a_z[CW-1], tri_in.a_z});
			vx_s1  <= $signed({tri_in.c_x[CW-1], tri_in.c_x}) - $signed({tri_in.b_x[CW-1], tri_in.b_x});
			vy_s1  <= $signed({tri_in.c_y[CW-1], tri_in.c_y}) - $signed({tri_in.b_y[CW-1], tri_in.b_y});
			vz_s1  <= $signed({tri_in.c_z[CW-1], tri_in.c_z}) - $signed({tri_in.b_z[CW-1], tri_in.b_z});
		end
	end

	// stage 2: six partial products
	logic                 vld_s2, cw_s2;
	logic signed [PW-1:0] p_s2 [6];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2  <= vld_s1;
			cw_s2   <= cw_s1;
			p_s2[0] <= uy_s1 * vz_s1;
			p_s2[1] <= uz_s1 * vy_s1;
			p_s2[2] <= uz_s1 * vx_s1;
			p_s2[3] <= ux_s1 * vz_s1;
			p_s2[4] <= ux_s1 * vy_s1;
			p_s2[5] <= uy_s1 * vx_s1;
		end
	end

	// stage 3: cross product components
	logic                 vld_s3, cw_s3;
	logic signed [XW-1:0] d_s3 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
			cw_s3  <= cw_s2;
			for (int j = 0; j < 3; j++) begin
				d_s3[j] <= $signed({p_s2[2*j][PW-1], p_s2[2*j]})
					- $signed({p_s2[2*j+1][PW-1], p_s2[2*j+1]});
			end
		end
	end

	// stage 4: sign and magnitude; clockwise winding flips every sign
	logic          vld_s4;
	logic [2:0]    neg_s4;
	logic [XW-1:0] mag_s4 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
			for (int j = 0; j < 3; j++) begin
				neg_s4[j] <= d_s3[j][XW-1] ^ cw_s3;
				mag_s4[j] <= d_s3[j][XW-1] ? XW'(-d_s3[j]) : XW'(d_s3[j]);
			end
		end
	end

	// stage 5: leading one of the largest magnitude gives the reduction shift
	logic [XW-1:0] orv;
	logic [LW-1:0] blen;
	always_comb begin
		orv  = mag_s4[0] | mag_s4[1] | mag_s4[2];
		blen = '0;
		for (int j = 0; j < XW; j++) begin
			if (orv[j]) begin
				blen = LW'(j + 1);
			end
		end
	end

	logic          vld_s5, degen_s5;
	logic [2:0]    neg_s5;
	logic [LW-1:0] k_s5;
	logic [XW-1:0] mag_s5 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5   <= vld_s4;
			neg_s5   <= neg_s4;
			degen_s5 <= (orv == '0);
			k_s5     <= (blen > LW'(RED)) ? blen - LW'(RED) : '0;
			mag_s5   <= mag_s4;
		end
	end

	// stage 6: reduced magnitudes
	logic           vld_s6, degen_s6;
	logic [2:0]     neg_s6;
	logic [RED-1:0] m_s6 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6   <= vld_s5;
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;
			for (int j = 0; j < 3; j++) begin
				m_s6[j] <= RED'(mag_s5[j] >> k_s5);
			end
		end
	end

	// stage 7: squares
	logic             vld_s7, degen_s7;
	logic [2:0]       neg_s7;
	logic [2*RED-1:0] sq_s7 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7   <= vld_s6;
			neg_s7   <= neg_s6;
			degen_s7 <= degen_s6;
			for (int j = 0; j < 3; j++) begin
				sq_s7[j] <= m_s6[j] * m_s6[j];
			end
		end
	end

	// stage 8: sum of squares
	logic             vld_s8, degen_s8;
	logic [2:0]       neg_s8;
	logic [2*RED-1:0] sq_s8 [3];
	logic [SW-1:0]    s_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8   <= vld_s7;
			neg_s8   <= neg_s7;
			degen_s8 <= degen_s7;
			sq_s8    <= sq_s7;
			s_s8     <= SW'(sq_s7[0]) + SW'(sq_s7[1]) + SW'(sq_s7[2]);
		end
	end

	tun_pkg::tun_tag_t tag_in  [3];
	tun_pkg::tun_tag_t tag_out [3];
	logic [TW-1:0]     root    [3];

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_lane
			assign tag_in[g] = '{vld: vld_s8, neg: neg_s8[g], degen: degen_s8};
			tun_lane #(.NF(NF)) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.tag_in  (tag_in[g]),
				.sq      (sq_s8[g]),
				.s       (s_s8),
				.tag_out (tag_out[g]),
				.root    (root[g])
			);
		end
	endgenerate

	// output register: round the root, apply sign, zero a degenerate result
	logic [TW-1:0] rmag [3];
	logic [TW-1:0] nrm  [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rmag[j] = TW'(({1'b0, root[j]} + (TW+1)'(1)) >> 1);
			if (tag_out[0].degen) begin
				nrm[j] = '0;
			end else if (tag_out[j].neg) begin
				nrm[j] = TW'(-rmag[j]);
			end else begin
				nrm[j] = rmag[j];
			end
		end
	end

	logic [TW-1:0] nx_q, ny_q, nz_q;
	logic          degen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= tag_out[0].vld;
			nx_q      <= nrm[0];
			ny_q      <= nrm[1];
			nz_q      <= nrm[2];
			degen_q   <= tag_out[0].degen;
		end
	end

	assign norm_out.valid      = out_vld_q;
	assign norm_out.normal_x   = $signed(nx_q);
	assign norm_out.normal_y   = $signed(ny_q);
	assign norm_out.normal_z   = $signed(nz_q);
	assign norm_out.degenerate = degen_q;
endmodule

>>> bench/tb_top.sv
// Self-checking bench for triangle_unit_normal: a directed table, then random triangles,
// each normal checked against a predictor of the cross product normalised to Q2.30.
// Depends on tun_pkg, tun_if and the design files.
module tb_top;
	localparam int LATENCY = 104;
	localparam int IDLE_LIMIT = 4000;
	localparam int N_RANDOM = 400;
	localparam int NF = 30;

	typedef struct {
		logic signed [31:0] v [9];
	} triangle_t;

	typedef struct {
		logic signed [31:0] nx, ny, nz;
		logic degen;
	} normal_t;

	typedef struct {
		int unsigned vx [9];
		logic has_exp;
		normal_t exp_n;
	} table_row_t;

	logic clk;
	logic arst_n;
	tun_tri_if  tri_ch ();
	tun_norm_if norm_ch ();
	tun_cfg_if  cfg_ch ();

	triangle_unit_normal dut (
		.clk(clk), .arst_n(arst_n), .tri_in(tri_ch.sink), .norm_out(norm_ch.source), .cfg(cfg_ch.sink)
	);

	logic winding_cw;
	normal_t normals_due [$];
	int errors;
	int idle_cycles;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// 128-bit sign/magnitude of p*q - r*s
	function automatic logic [127:0] cross_mag(longint p, longint q, longint r, longint s,
			output logic neg);
		logic signed [127:0] d;
		d = 128'(signed'(p)) * 128'(signed'(q)) - 128'(signed'(r)) * 128'(signed'(s));
		neg = d[127];
		return neg ? -d : d;
	endfunction

	function automatic logic [31:0] unit_component(logic [63:0] m, logic [63:0] s);
		logic [127:0] num;
		logic [127:0] q;
		logic [63:0] t;
		logic [63:0] c;
		num = {64'd0, m * m} << (2 * NF + 2);
		q = num / s;
		t = 0;
		for (int b = NF + 1; b >= 0; b--) begin
			c = t | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= q)
				t = c;
		end
		return 32'((t + 1) >> 1);
	endfunction

	function automatic normal_t predict_normal(triangle_t tr, logic cw);
		normal_t n;
		longint ux, uy, uz, vx, vy, vz;
		logic [127:0] mag [3];
		logic neg [3];
		logic [127:0] all;
		logic [63:0] m [3];
		logic [63:0] s;
		logic [31:0] r [3];
		int len, k;
		ux = longint'(tr.v[3]) - longint'(tr.v[0]);
		uy = longint'(tr.v[4]) - longint'(tr.v[1]);
		uz = longint'(tr.v[5]) - longint'(tr.v[2]);
		vx = longint'(tr.v[6]) - longint'(tr.v[3]);
		vy = longint'(tr.v[7]) - longint'(tr.v[4]);
		vz = longint'(tr.v[8]) - longint'(tr.v[5]);
		mag[0] = cross_mag(uy, vz, uz, vy, neg[0]);
		mag[1] = cross_mag(uz, vx, ux, vz, neg[1]);
		mag[2] = cross_mag(ux, vy, uy, vx, neg[2]);
		all = mag[0] | mag[1] | mag[2];
		if (all == 0) begin
			n.nx = 0; n.ny = 0; n.nz = 0; n.degen = 1;
			return n;
		end
		len = 0;
		for (int i = 0; i < 128; i++)
			if (all[i]) len = i + 1;
		k = len > tun_pkg::RED_BITS ? len - tun_pkg::RED_BITS : 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = 64'(mag[i] >> k);
			s += m[i] * m[i];
		end
		for (int i = 0; i < 3; i++) begin
			r[i] = unit_component(m[i], s);
			if (neg[i] ^ cw) r[i] = -r[i];
		end
		n.nx = r[0]; n.ny = r[1]; n.nz = r[2]; n.degen = 0;
		return n;
	endfunction

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// valid stays high between back-to-back transactions unless a random gap drops it; drain() drops it
	task automatic send_triangle(triangle_t tr, logic has_exp, normal_t exp_n);
		normal_t p;
		int gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			tri_ch.valid <= 0;
			wait_cycles(gap);
		end
		tri_ch.valid <= 1;
		tri_ch.a_x <= tr.v[0]; tri_ch.a_y <= tr.v[1]; tri_ch.a_z <= tr.v[2];
		tri_ch.b_x <= tr.v[3]; tri_ch.b_y <= tr.v[4]; tri_ch.b_z <= tr.v[5];
		tri_ch.c_x <= tr.v[6]; tri_ch.c_y <= tr.v[7]; tri_ch.c_z <= tr.v[8];
		do @(posedge clk); while (!tri_ch.ready);
		p = predict_normal(tr, winding_cw);
		if (has_exp) begin
			if (p.nx !== exp_n.nx) begin
				$error("table normal_x exp %0d got %0d", exp_n.nx, p.nx); errors++;
			end
			if (p.ny !== exp_n.ny) begin
				$error("table normal_y exp %0d got %0d", exp_n.ny, p.ny); errors++;
			end
			if (p.nz !== exp_n.nz) begin
				$error("table normal_z exp %0d got %0d", exp_n.nz, p.nz); errors++;
			end
			if (p.degen !== exp_n.degen) begin
				$error("table degenerate exp %0d got %0d", exp_n.degen, p.degen); errors++;
			end
		end
		normals_due.push_back(p);
	endtask

	task automatic drain();
		tri_ch.valid <= 0;
		while (normals_due.size() != 0) @(posedge clk);
		wait_cycles(LATENCY + 4);
	endtask

	task automatic write_winding(logic cw);
		cfg_ch.valid <= 1;
		cfg_ch.data <= cw;
		do @(posedge clk); while (!cfg_ch.ready);
		winding_cw = cw;
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	function automatic int unsigned random_coord();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 255) << 16;
			2: return -($urandom_range(0, 255) << 16);
			3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	// output side: random stall, compare against oldest expectation
	always @(posedge clk) begin
		if (norm_ch.valid && norm_ch.ready) begin
			if (normals_due.size() == 0) begin
				$error("unexpected normal transaction");
				errors++;
			end else begin
				normal_t e;
				e = normals_due.pop_front();
				if (norm_ch.normal_x !== e.nx) begin
					$error("normal_x exp %0d got %0d", e.nx, norm_ch.normal_x); errors++;
				end
				if (norm_ch.normal_y !== e.ny) begin
					$error("normal_y exp %0d got %0d", e.ny, norm_ch.normal_y); errors++;
				end
				if (norm_ch.normal_z !== e.nz) begin
					$error("normal_z exp %0d got %0d", e.nz, norm_ch.normal_z); errors++;
				end
				if (norm_ch.degenerate !== e.degen) begin
					$error("degenerate exp %0d got %0d", e.degen, norm_ch.degenerate);
					errors++;
				end
			end
		end
	end

	initial begin
		int stall;
		norm_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				norm_ch.ready <= 0;
			end else begin
				norm_ch.ready <= 1;
				if (norm_ch.valid && norm_ch.ready)
					stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
			end
		end
	end

	// watchdog: count cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((tri_ch.valid && tri_ch.ready) || (norm_ch.valid && norm_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		table_row_t rows [$];
		table_row_t row;
		triangle_t tr;
		normal_t zero_n;
		errors = 0;
		idle_cycles = 0;
		winding_cw = 0;
		arst_n = 0;
		tri_ch.valid = 0;
		cfg_ch.valid = 0;
		cfg_ch.data = 0;
		{tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z,
			tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
		zero_n = '{0, 0, 0, 0};
		wait_cycles(6);
		arst_n <= 1;
		@(posedge clk);

		// all-zero triangle degenerate; unit triangle in xy gives +z
		row.vx = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		row.has_exp = 1; row.exp_n = '{0, 0, 0, 1}; rows.push_back(row);
		row.vx = '{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0};
		row.exp_n = '{0, 0, 32'h40000000, 0}; rows.push_back(row);
		row.vx = '{0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000};
		row.exp_n = '{32'h40000000, 0, 0, 0}; rows.push_back(row);
		row.vx = '{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 32'h10000};
		row.exp_n = '{0, 32'h40000000, 0, 0}; rows.push_back(row);
		// collinear points: degenerate
		row.vx = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
		row.exp_n = '{0, 0, 0, 1}; rows.push_back(row);
		row.has_exp = 0;
		row.vx = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
		rows.push_back(row);
		row.vx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000};
		rows.push_back(row);
		row.vx = '{32'hffffffff, 0, 1, 0, 32'hffffffff, 0, 1, 1, 32'hffffffff};
		rows.push_back(row);
		row.vx = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		rows.push_back(row);
		row.vx = '{5, 7, 11, 32'h12345, 32'h54321, 32'hfedcba, 32'h80000000, 32'h7fffffff, 3};
		rows.push_back(row);

		for (int ph = 0; ph < 2; ph++) begin
			foreach (rows[i]) begin
				for (int j = 0; j < 9; j++) tr.v[j] = rows[i].vx[j];
				// expected values in the table hold for counter-clockwise only
				send_triangle(tr, rows[i].has_exp && !winding_cw, rows[i].exp_n);
			end
			drain();
			write_winding(ph == 0);
		end
		write_winding(0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				drain();
				write_winding(1);
			end
			if (n == 100) drain();
			for (int j = 0; j < 9; j++) tr.v[j] = random_coord();
			// some shared vertices so degenerate triangles appear at random too
			if ($urandom_range(0, 19) == 0) tr.v[6:8] = tr.v[3:5];
			send_triangle(tr, 0, zero_n);
		end
		drain();

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
